// ===== hw/rtl/cpfa_pkg.sv =====
// cpfa_pkg: types, constants and geometry of the channel parameter field access block.
// Used by every module under hw/rtl except cpfa_ram; depends on nothing.
package cpfa_pkg;

   localparam int NUM_CHANNELS      = 64;
   localparam int WORD_BITS         = 160;
   localparam int WORDS_PER_CHANNEL = 2;
   localparam int SUB_W             = 32;
   localparam int SUBWORDS          = (WORD_BITS + SUB_W - 1) / SUB_W;
   localparam int MEM_DEPTH         = NUM_CHANNELS * WORDS_PER_CHANNEL * SUBWORDS;
   localparam int BANK_DEPTH        = (MEM_DEPTH + 1) / 2;
   localparam int ADDR_W            = $clog2(MEM_DEPTH);
   localparam int ROW_W             = $clog2(BANK_DEPTH);

   localparam int CH_W      = 6;
   localparam int START_W   = 9;
   localparam int SIZE_W    = 6;
   localparam int OFS_W     = $clog2(SUB_W);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int MAX_WORD  = (2 ** START_W - 1) / WORD_BITS;
   localparam int WORD_W    = $clog2(MAX_WORD + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [CH_W-1:0]    channel_index;
      logic [START_W-1:0] field_start_bit;
      logic [SIZE_W-1:0]  field_size;
      logic [SUB_W-1:0]   write_value;
   } req_type;

   typedef struct packed {
      logic [SUB_W-1:0] read_value;
      logic             range_error;
   } rsp_type;

   typedef struct packed {
      logic              is_write;
      logic              refused;
      logic              empty_field;
      logic              two;
      logic [OFS_W-1:0]  ofs;
      logic [ADDR_W-1:0] addr;
      logic [SUB_W-1:0]  mask;
      logic [SUB_W-1:0]  wval;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY
   } back_state_type;

endpackage

// ===== hw/rtl/channel_param_field_access.sv =====
// Channel parameter field access: bit-field read/write into a per-channel parameter memory.
// Path: command queue, back-end command register (with registered bank read), result register.
// The back end handles one command at a time: the registered read of the RAM banks comes before
// its read-modify-write, which waits for a free result register; a 2-entry command queue
// decouples decode from execution. Reset: synchronous; afterwards a clearing pass zeroes the
// memory with req_full high. Depends on cpfa_pkg, cpfa_front, cpfa_queue, cpfa_back.
module channel_param_field_access (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cpfa_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cpfa_pkg::rsp_type rsp_data
);
   import cpfa_pkg::*;

   cmd_type dec_cmd, head_cmd;
   logic    q_full, q_empty, q_pop, clearing;

   cpfa_front u_front (
      .req (req_data),
      .cmd (dec_cmd)
   );

   cpfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !clearing),
      .push_data (dec_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_cmd),
      .empty     (q_empty)
   );

   cpfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign req_full = q_full || clearing;
endmodule

// ===== hw/rtl/cpfa_ram.sv =====
// cpfa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 320
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/cpfa_front.sv =====
// cpfa_front: decodes a request beat into a memory command (address, offset, mask, refusal).
// Depends on cpfa_pkg.
module cpfa_front (
   input  cpfa_pkg::req_type req,
   output cpfa_pkg::cmd_type cmd
);
   import cpfa_pkg::*;

   logic [WORD_W-1:0] word;
   logic [BIT_W-1:0]  bit_pos;
   logic [SIZE_W-1:0] size_sat;
   logic              refused;

   always_comb begin
      word = '0;
      for (int k = 1; k <= MAX_WORD; k++) begin
         if (req.field_start_bit >= START_W'(k * WORD_BITS)) begin
            word = WORD_W'(k);
         end
      end
      bit_pos = BIT_W'(req.field_start_bit - START_W'(int'(word) * WORD_BITS));
      size_sat = (req.field_size > SIZE_W'(SUB_W)) ? SIZE_W'(SUB_W) : req.field_size;
      refused = (int'(req.channel_index) >= NUM_CHANNELS) ||
                (int'(word) >= WORDS_PER_CHANNEL) ||
                ((int'(bit_pos) + int'(size_sat)) > WORD_BITS);

      cmd.is_write    = (req.opcode == OP_WRITE);
      cmd.refused     = refused;
      cmd.empty_field = (size_sat == '0);
      cmd.ofs         = bit_pos[OFS_W-1:0];
      cmd.two         = ((OFS_W+2)'(bit_pos[OFS_W-1:0]) + (OFS_W+2)'(size_sat)) >
                        (OFS_W+2)'(SUB_W);
      cmd.addr        = refused ? '0 :
                        ADDR_W'(int'(req.channel_index) * WORDS_PER_CHANNEL * SUBWORDS +
                                int'(word) * SUBWORDS + int'(bit_pos >> OFS_W));
      cmd.mask        = SUB_W'(((SUB_W+1)'(1) << size_sat) - (SUB_W+1)'(1));
      cmd.wval        = req.write_value & cmd.mask;
   end
endmodule

// ===== hw/rtl/cpfa_queue.sv =====
// cpfa_queue: short command queue between the decode front and the memory back end.
// Depends on cpfa_pkg.
module cpfa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cpfa_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output cpfa_pkg::cmd_type pop_data,
   output logic              empty
);
   import cpfa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'((int'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'((int'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/cpfa_back.sv =====
// cpfa_back: executes commands on the parameter memory (even/odd subword banks),
// clears it after reset and holds the result register. Depends on cpfa_pkg, cpfa_ram.
module cpfa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cpfa_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              clearing,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cpfa_pkg::rsp_type rsp_data
);
   import cpfa_pkg::*;

   back_state_type   state_ff, state_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;
   cmd_type          cur_ff, cur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             rd_en;
   logic [ROW_W-1:0] even_rd_row, odd_rd_row;
   logic [SUB_W-1:0] even_rd_data, odd_rd_data;
   logic             even_we, odd_we;
   logic [ROW_W-1:0] even_wr_row, odd_wr_row;
   logic [SUB_W-1:0] even_wr_data, odd_wr_data;

   logic [ROW_W-1:0]     cur_row;
   logic                 cur_odd;
   logic [SUB_W-1:0]     lo_data, hi_data;
   logic [2*SUB_W-1:0]   window, field_mask, merged;
   logic                 out_free, commit, do_write;

   cpfa_ram #(.WIDTH(SUB_W), .DEPTH(BANK_DEPTH)) u_even (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_wr_row),
      .wr_data (even_wr_data),
      .rd_en   (rd_en),
      .rd_addr (even_rd_row),
      .rd_data (even_rd_data)
   );

   cpfa_ram #(.WIDTH(SUB_W), .DEPTH(BANK_DEPTH)) u_odd (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_wr_row),
      .wr_data (odd_wr_data),
      .rd_en   (rd_en),
      .rd_addr (odd_rd_row),
      .rd_data (odd_rd_data)
   );

   // read side: two adjacent subwords always sit in opposite banks
   always_comb begin
      rd_en       = (state_ff == ST_IDLE) && cmd_valid;
      odd_rd_row  = cmd.addr[ADDR_W-1:1];
      even_rd_row = (cmd.addr[0] && cmd.two) ? cmd.addr[ADDR_W-1:1] + ROW_W'(1)
                                             : cmd.addr[ADDR_W-1:1];
   end

   always_comb begin
      cur_row    = cur_ff.addr[ADDR_W-1:1];
      cur_odd    = cur_ff.addr[0];
      lo_data    = cur_odd ? odd_rd_data : even_rd_data;
      hi_data    = cur_odd ? even_rd_data : odd_rd_data;
      window     = {hi_data, lo_data};
      field_mask = {{SUB_W{1'b0}}, cur_ff.mask} << cur_ff.ofs;
      merged     = (window & ~field_mask) | ({{SUB_W{1'b0}}, cur_ff.wval} << cur_ff.ofs);
   end

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      out_free     = !rsp_valid_ff || rsp_pop;
      commit       = 1'b0;

      even_we      = 1'b0;
      odd_we       = 1'b0;
      even_wr_row  = cur_row;
      odd_wr_row   = cur_row;
      even_wr_data = '0;
      odd_wr_data  = '0;

      case (state_ff)
         ST_CLEAR: begin
            even_we     = 1'b1;
            odd_we      = 1'b1;
            even_wr_row = clr_row_ff;
            odd_wr_row  = clr_row_ff;
            clr_row_in  = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == ROW_W'(BANK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (out_free) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.range_error = cur_ff.refused;
               rsp_in.read_value  = (cur_ff.is_write || cur_ff.refused) ? '0 :
                                    SUB_W'(window >> cur_ff.ofs) & cur_ff.mask;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      do_write = commit && cur_ff.is_write && !cur_ff.refused && !cur_ff.empty_field;
      if (do_write) begin
         even_we      = !cur_odd || cur_ff.two;
         odd_we       = cur_odd || cur_ff.two;
         even_wr_row  = cur_odd ? cur_row + ROW_W'(1) : cur_row;
         odd_wr_row   = cur_row;
         even_wr_data = cur_odd ? merged[2*SUB_W-1:SUB_W] : merged[SUB_W-1:0];
         odd_wr_data  = cur_odd ? merged[SUB_W-1:0] : merged[2*SUB_W-1:SUB_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== hw/rtl/cpfa_checker.sv =====
// cpfa_checker: port-level assertions for channel_param_field_access, bound to the top level.
// Depends on cpfa_pkg.
module cpfa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input cpfa_pkg::req_type req_data,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input cpfa_pkg::rsp_type rsp_data
);
   import cpfa_pkg::*;

   // memory clear must block requests right after reset
   a_full_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("req_full low right after reset");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |-> !$isunknown(req_data))
      else $error("accepted request beat carries unknown bits");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.range_error) |-> (rsp_data.read_value == '0))
      else $error("refused beat carries nonzero read_value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");
endmodule

bind channel_param_field_access cpfa_checker u_cpfa_checker (.*);
